// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/ihh_pkg.sv
// ---------------------------------------------------------------------------
// ihh_pkg
// Codes, defaults and the sequencer state type of the indexed min-heap.
// ---------------------------------------------------------------------------
package ihh_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 31;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;
    localparam logic [1:0] ACT_DELMIN = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_MISS  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLEAR,
        ST_PROBE_CMP,
        ST_DECIDE,
        ST_RM_GET,
        ST_DM_GET,
        ST_TAKE,
        ST_TO_GET,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_PLACE,
        ST_DONE
    } ihh_state_t;

endpackage

// File: hw/rtl/ihh_req_if.sv
// ---------------------------------------------------------------------------
// ihh_req_if
// Request channel: action and key with valid/ready.
// ---------------------------------------------------------------------------
interface ihh_req_if #(
    parameter int KEY_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, action, key, input ready);
    modport sink   (input valid, action, key, output ready);
endinterface

// File: hw/rtl/ihh_rsp_if.sv
// ---------------------------------------------------------------------------
// ihh_rsp_if
// Result channel: status and removed minimum key with valid/ready.
// ---------------------------------------------------------------------------
interface ihh_rsp_if #(
    parameter int KEY_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [KEY_BITS-1:0] min_key;

    modport source (output valid, status, min_key, input ready);
    modport sink   (input valid, status, min_key, output ready);
endinterface

// File: hw/rtl/indexed_min_heap_with_hash_lookup.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_with_hash_lookup
// Priority queue of distinct keys: binary min-heap plus linear-probing hash.
// ---------------------------------------------------------------------------
// One request at a time, one result per request. After reset the block
// clears the slot used and tombstone flags of every slot in their memory,
// with the request side held off. Insert, remove and find first compute
// the home slot (key modulo TABLE_DEPTH: the low key bits for a power of
// two depth, else a radix-16 compare and subtract remainder over the
// ceil(KEY_BITS/4) key digits), then probe the hash table at one slot per
// cycle, reading flags and key together, until a never-used slot, a match
// or a full lap. A find then decides and reports its result. Heap repair
// is a hole-based sift through a single-port-read heap memory: each level
// going up reads the parent and compares; each level going down reads the
// left child, then the right child, then compares; a final step places the
// moving entry. A delete minimum first reads the root, shrinks the heap and
// fetches the last entry into the hole. Key and link memories need no
// clearing. The next request is taken while the previous result still
// waits in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_heap_with_hash_lookup #(
    parameter int TABLE_DEPTH = ihh_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = ihh_pkg::KEY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ihh_req_if.sink   req,
    ihh_rsp_if.source rsp
);
    import ihh_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int HW = KEY_BITS + AW;
    localparam int NDIG = (KEY_BITS + 3) / 4;
    localparam int KB4 = 4 * NDIG;
    localparam int MCW = $clog2(NDIG + 1);
    localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Memories: slot keys, slot flags {used, tombstone}, slot-to-heap links,
    // heap entries {key, slot}.
    logic [KEY_BITS-1:0] slot_key_mem [TABLE_DEPTH];
    logic [1:0]          flag_mem     [TABLE_DEPTH];
    logic [AW-1:0]       slot_pos_mem [TABLE_DEPTH];
    logic [HW-1:0]       heap_mem     [TABLE_DEPTH];

    logic                slot_key_we, slot_pos_we, heap_we, flag_we;
    logic [AW-1:0]       slot_key_wa, slot_pos_wa, heap_wa, flag_wa;
    logic [AW-1:0]       slot_key_ra, slot_pos_ra, heap_ra;
    logic [KEY_BITS-1:0] slot_key_wd, slot_key_rd;
    logic [AW-1:0]       slot_pos_wd, slot_pos_rd;
    logic [HW-1:0]       heap_wd, heap_rd;
    logic [1:0]          flag_wd, flag_rd;

    always_ff @(posedge clk)
    begin
        if (slot_key_we)
        begin
            slot_key_mem[slot_key_wa] <= slot_key_wd;
        end
        slot_key_rd <= slot_key_mem[slot_key_ra];
    end

    // Flags share the probe address with the slot keys.
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        flag_rd <= flag_mem[slot_key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (slot_pos_we)
        begin
            slot_pos_mem[slot_pos_wa] <= slot_pos_wd;
        end
        slot_pos_rd <= slot_pos_mem[slot_pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_rd <= heap_mem[heap_ra];
    end

    // Split the heap read word and the flag word.
    logic [KEY_BITS-1:0] rd_key;
    logic [AW-1:0]       rd_slot;
    logic                rd_used, rd_del;
    assign rd_key  = heap_rd[HW-1:AW];
    assign rd_slot = heap_rd[AW-1:0];
    assign rd_used = flag_rd[1];
    assign rd_del  = flag_rd[0];

    // Control and datapath registers.
    ihh_state_t          state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [1:0]          act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KB4-1:0]      mod_sh_reg, mod_sh_next;
    logic [AW-1:0]       mod_r_reg, mod_r_next;
    logic [MCW-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [AW-1:0]       probe_idx_reg, probe_idx_next;
    logic [CW-1:0]       probe_cnt_reg, probe_cnt_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       hit_reg, hit_next;
    logic                free_v_reg, free_v_next;
    logic [AW-1:0]       free_reg, free_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [KEY_BITS-1:0] mv_key_reg, mv_key_next;
    logic [AW-1:0]       mv_slot_reg, mv_slot_next;
    logic                up_only_reg, up_only_next;
    logic [KEY_BITS-1:0] lk_reg, lk_next;
    logic [AW-1:0]       ls_reg, ls_next;
    logic                has_r_reg, has_r_next;
    logic [1:0]          status_reg, status_next;
    logic [KEY_BITS-1:0] min_reg, min_next;
    logic                out_v_reg, out_v_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [KEY_BITS-1:0] out_min_reg, out_min_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        mod_sh_reg     <= mod_sh_next;
        mod_r_reg      <= mod_r_next;
        mod_cnt_reg    <= mod_cnt_next;
        probe_idx_reg  <= probe_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        free_v_reg     <= free_v_next;
        free_reg       <= free_next;
        pos_reg        <= pos_next;
        mv_key_reg     <= mv_key_next;
        mv_slot_reg    <= mv_slot_next;
        up_only_reg    <= up_only_next;
        lk_reg         <= lk_next;
        ls_reg         <= ls_next;
        has_r_reg      <= has_r_next;
        status_reg     <= status_next;
        min_reg        <= min_next;
        out_status_reg <= out_status_next;
        out_min_reg    <= out_min_next;
    end

    // Helpers shared by the sequencer.
    logic [AW+KEY_BITS-1:0] key_wide;
    logic [AW+3:0]          mod_v, mod_sub, mod_diff;
    logic [CW-1:0]          probe_cnt_inc;
    logic [AW-1:0]          probe_idx_inc;
    logic [AW-1:0]          parent_idx;
    logic [CW-1:0]          left_c, right_c, last_c;

    assign key_wide      = {{AW{1'b0}}, req.key};
    assign mod_v         = {mod_r_reg, mod_sh_reg[KB4-1 -: 4]};
    assign mod_diff      = mod_v - mod_sub;
    assign probe_cnt_inc = probe_cnt_reg + 1'b1;
    assign probe_idx_inc = ({1'b0, probe_idx_reg} == DEPTH_C - 1'b1)
                           ? '0 : probe_idx_reg + 1'b1;
    assign parent_idx    = (pos_reg - 1'b1) >> 1;
    assign left_c        = {pos_reg, 1'b1};
    assign right_c       = left_c + 1'b1;
    assign last_c        = count_reg - 1'b1;

    // Remainder digit step: take the largest multiple of the depth that fits.
    always_comb
    begin
        mod_sub = '0;
        for (int j = 1; j < 16; j++)
        begin
            if (mod_v >= (AW+4)'(j * TABLE_DEPTH))
            begin
                mod_sub = (AW+4)'(j * TABLE_DEPTH);
            end
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_v_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.min_key = out_min_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        mod_sh_next     = mod_sh_reg;
        mod_r_next      = mod_r_reg;
        mod_cnt_next    = mod_cnt_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        free_v_next     = free_v_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        mv_key_next     = mv_key_reg;
        mv_slot_next    = mv_slot_reg;
        up_only_next    = up_only_reg;
        lk_next         = lk_reg;
        ls_next         = ls_reg;
        has_r_next      = has_r_reg;
        status_next     = status_reg;
        min_next        = min_reg;
        out_v_next      = out_v_reg;
        out_status_next = out_status_reg;
        out_min_next    = out_min_reg;

        slot_key_we = 1'b0;
        slot_key_wa = free_reg;
        slot_key_wd = key_reg;
        slot_key_ra = probe_idx_reg;
        flag_we     = 1'b0;
        flag_wa     = free_reg;
        flag_wd     = 2'b10;
        slot_pos_we = 1'b0;
        slot_pos_wa = rd_slot;
        slot_pos_wd = pos_reg;
        slot_pos_ra = hit_reg;
        heap_we     = 1'b0;
        heap_wa     = pos_reg;
        heap_wd     = heap_rd;
        heap_ra     = '0;

        // Drop the result once taken.
        if (rsp.ready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Walk every slot once after reset: never used, no tombstone.
                flag_we = 1'b1;
                flag_wa = clr_reg;
                flag_wd = 2'b00;
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.action;
                    key_next    = req.key;
                    min_next    = '0;
                    status_next = STS_OK;
                    found_next  = 1'b0;
                    free_v_next = 1'b0;
                    probe_cnt_next = '0;
                    if (req.action == ACT_DELMIN)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            heap_ra    = '0;
                            state_next = ST_DM_GET;
                        end
                    end
                    else if (IS_POW2)
                    begin
                        probe_idx_next = key_wide[AW-1:0];
                        slot_key_ra    = key_wide[AW-1:0];
                        state_next     = ST_PROBE_CMP;
                    end
                    else
                    begin
                        mod_sh_next  = KB4'(req.key);
                        mod_r_next   = '0;
                        mod_cnt_next = MCW'(NDIG);
                        state_next   = ST_MOD;
                    end
                end
            end

            ST_MOD:
            begin
                // Four key bits per cycle into the remainder.
                mod_r_next   = mod_diff[AW-1:0];
                mod_sh_next  = mod_sh_reg << 4;
                mod_cnt_next = mod_cnt_reg - 1'b1;
                if (mod_cnt_reg == MCW'(1))
                begin
                    probe_idx_next = mod_diff[AW-1:0];
                    slot_key_ra    = mod_diff[AW-1:0];
                    state_next     = ST_PROBE_CMP;
                end
            end

            ST_PROBE_CMP:
            begin
                // Flags and key of probe_idx_reg are on the read ports.
                if (!rd_used)
                begin
                    // Never-used slot ends the probe.
                    if (!free_v_reg)
                    begin
                        free_v_next = 1'b1;
                        free_next   = probe_idx_reg;
                    end
                    state_next = ST_DECIDE;
                end
                else if (!rd_del && slot_key_rd == key_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = probe_idx_reg;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    if (rd_del && !free_v_reg)
                    begin
                        free_v_next = 1'b1;
                        free_next   = probe_idx_reg;
                    end
                    probe_cnt_next = probe_cnt_inc;
                    probe_idx_next = probe_idx_inc;
                    slot_key_ra    = probe_idx_inc;
                    if (probe_cnt_inc == DEPTH_C)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = STS_MISS;
                            state_next  = ST_DONE;
                        end
                        else if (!free_v_reg || count_reg >= DEPTH_C)
                        begin
                            status_next = STS_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            slot_key_we = 1'b1;
                            slot_key_wa = free_reg;
                            slot_key_wd = key_reg;
                            flag_we      = 1'b1;
                            flag_wa      = free_reg;
                            flag_wd      = 2'b10;
                            mv_key_next  = key_reg;
                            mv_slot_next = free_reg;
                            pos_next     = count_reg[AW-1:0];
                            count_next   = count_reg + 1'b1;
                            up_only_next = 1'b1;
                            state_next   = ST_UP_RD;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = STS_MISS;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            flag_we     = 1'b1;
                            flag_wa     = hit_reg;
                            flag_wd     = 2'b11;
                            slot_pos_ra = hit_reg;
                            state_next  = ST_RM_GET;
                        end
                    end
                    default:
                    begin
                        // Find: report only.
                        status_next = found_reg ? STS_OK : STS_MISS;
                        state_next  = ST_DONE;
                    end
                endcase
            end

            ST_RM_GET:
            begin
                pos_next   = slot_pos_rd;
                state_next = ST_TAKE;
            end

            ST_DM_GET:
            begin
                min_next   = rd_key;
                flag_we    = 1'b1;
                flag_wa    = rd_slot;
                flag_wd    = 2'b11;
                pos_next   = '0;
                state_next = ST_TAKE;
            end

            ST_TAKE:
            begin
                // Shrink the heap; refill the hole from the last entry.
                count_next = last_c;
                if ({1'b0, pos_reg} == last_c)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    heap_ra    = last_c[AW-1:0];
                    state_next = ST_TO_GET;
                end
            end

            ST_TO_GET:
            begin
                mv_key_next  = rd_key;
                mv_slot_next = rd_slot;
                up_only_next = 1'b0;
                state_next   = ST_UP_RD;
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = up_only_reg ? ST_PLACE : ST_DN_L;
                end
                else
                begin
                    heap_ra    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                if (mv_key_reg < rd_key)
                begin
                    // Move the parent down into the hole.
                    heap_we     = 1'b1;
                    heap_wa     = pos_reg;
                    heap_wd     = heap_rd;
                    slot_pos_we = 1'b1;
                    slot_pos_wa = rd_slot;
                    slot_pos_wd = pos_reg;
                    pos_next    = parent_idx;
                    state_next  = ST_UP_RD;
                end
                else
                begin
                    state_next = up_only_reg ? ST_PLACE : ST_DN_L;
                end
            end

            ST_DN_L:
            begin
                if (left_c >= count_reg)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    heap_ra    = left_c[AW-1:0];
                    state_next = ST_DN_R;
                end
            end

            ST_DN_R:
            begin
                lk_next = rd_key;
                ls_next = rd_slot;
                if (right_c < count_reg)
                begin
                    heap_ra    = right_c[AW-1:0];
                    has_r_next = 1'b1;
                end
                else
                begin
                    has_r_next = 1'b0;
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                if (has_r_reg && rd_key < lk_reg)
                begin
                    if (rd_key < mv_key_reg)
                    begin
                        heap_we     = 1'b1;
                        heap_wa     = pos_reg;
                        heap_wd     = heap_rd;
                        slot_pos_we = 1'b1;
                        slot_pos_wa = rd_slot;
                        slot_pos_wd = pos_reg;
                        pos_next    = right_c[AW-1:0];
                        state_next  = ST_DN_L;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else if (lk_reg < mv_key_reg)
                begin
                    heap_we     = 1'b1;
                    heap_wa     = pos_reg;
                    heap_wd     = {lk_reg, ls_reg};
                    slot_pos_we = 1'b1;
                    slot_pos_wa = ls_reg;
                    slot_pos_wd = pos_reg;
                    pos_next    = left_c[AW-1:0];
                    state_next  = ST_DN_L;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                heap_we     = 1'b1;
                heap_wa     = pos_reg;
                heap_wd     = {mv_key_reg, mv_slot_reg};
                slot_pos_we = 1'b1;
                slot_pos_wa = mv_slot_reg;
                slot_pos_wd = pos_reg;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_v_reg || rsp.ready)
                begin
                    out_v_next      = 1'b1;
                    out_status_next = status_reg;
                    out_min_next    = min_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req.valid && req.ready, state_reg != ST_IDLE)
    `ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(out_v_reg), $past(state_reg == ST_DONE))
    `ASSERT_IMPLIES(a_empty_means_zero, clk, rst_n, state_reg == ST_DONE && status_reg == STS_EMPTY, count_reg == '0)

endmodule
